// ===== hw/rtl/mcce_pkg.sv =====
// Package: shared types, case table and helpers for the cell extractor.
package mcce_pkg;

  localparam int CoordW = 8;
  localparam int CntW   = 28;
  localparam int PosW   = 16;
  localparam int NumEdges = 12;

  // Corner offsets packed {z,y,x}.
  function automatic logic [2:0] corner_off(input logic [2:0] c);
    logic [2:0] r;
    begin
      case (c)
        3'd0: r = 3'b000;
        3'd1: r = 3'b001;
        3'd2: r = 3'b011;
        3'd3: r = 3'b010;
        3'd4: r = 3'b100;
        3'd5: r = 3'b101;
        3'd6: r = 3'b111;
        default: r = 3'b110;
      endcase
      return r;
    end
  endfunction

  // Edge endpoints {a,b}.
  function automatic logic [5:0] edge_ends(input logic [3:0] e);
    logic [5:0] r;
    begin
      case (e)
        4'd0:  r = {3'd0, 3'd1};
        4'd1:  r = {3'd1, 3'd2};
        4'd2:  r = {3'd2, 3'd3};
        4'd3:  r = {3'd3, 3'd0};
        4'd4:  r = {3'd4, 3'd5};
        4'd5:  r = {3'd5, 3'd6};
        4'd6:  r = {3'd6, 3'd7};
        4'd7:  r = {3'd7, 3'd4};
        4'd8:  r = {3'd0, 3'd4};
        4'd9:  r = {3'd1, 3'd5};
        4'd10: r = {3'd2, 3'd6};
        default: r = {3'd3, 3'd7};
      endcase
      return r;
    end
  endfunction

  // Triangle table: 15 nibbles per case (entry 0 in low nibble), 4'hf ends.
  typedef logic [59:0] tri_row_t;

  function automatic tri_row_t tri_row(input logic [7:0] cs);
    logic [3:0] v [15];
    tri_row_t r;
    begin
      for (int k = 0; k < 15; k++) v[k] = 4'hf;
      case (cs)
        8'd1: begin v[0]=0;v[1]=8;v[2]=3; end
        8'd2: begin v[0]=0;v[1]=1;v[2]=9; end
        8'd3: begin v[0]=1;v[1]=8;v[2]=3;v[3]=9;v[4]=8;v[5]=1; end
        8'd4: begin v[0]=1;v[1]=2;v[2]=10; end
        8'd5: begin v[0]=0;v[1]=8;v[2]=3;v[3]=1;v[4]=2;v[5]=10; end
        8'd6: begin v[0]=9;v[1]=2;v[2]=10;v[3]=0;v[4]=2;v[5]=9; end
        8'd7: begin v[0]=2;v[1]=8;v[2]=3;v[3]=2;v[4]=10;v[5]=8;v[6]=10;v[7]=9;v[8]=8; end
        8'd8: begin v[0]=3;v[1]=11;v[2]=2; end
        8'd9: begin v[0]=0;v[1]=11;v[2]=2;v[3]=8;v[4]=11;v[5]=0; end
        8'd10: begin v[0]=1;v[1]=9;v[2]=0;v[3]=2;v[4]=3;v[5]=11; end
        8'd11: begin v[0]=1;v[1]=11;v[2]=2;v[3]=1;v[4]=9;v[5]=11;v[6]=9;v[7]=8;v[8]=11; end
        8'd12: begin v[0]=3;v[1]=10;v[2]=1;v[3]=11;v[4]=10;v[5]=3; end
        8'd13: begin v[0]=0;v[1]=10;v[2]=1;v[3]=0;v[4]=8;v[5]=10;v[6]=8;v[7]=11;v[8]=10; end
        8'd14: begin v[0]=3;v[1]=9;v[2]=0;v[3]=3;v[4]=11;v[5]=9;v[6]=11;v[7]=10;v[8]=9; end
        8'd15: begin v[0]=9;v[1]=8;v[2]=10;v[3]=10;v[4]=8;v[5]=11; end
        8'd16: begin v[0]=4;v[1]=7;v[2]=8; end
        8'd17: begin v[0]=4;v[1]=3;v[2]=0;v[3]=7;v[4]=3;v[5]=4; end
        8'd18: begin v[0]=0;v[1]=1;v[2]=9;v[3]=8;v[4]=4;v[5]=7; end
        8'd19: begin v[0]=4;v[1]=1;v[2]=9;v[3]=4;v[4]=7;v[5]=1;v[6]=7;v[7]=3;v[8]=1; end
        8'd20: begin v[0]=1;v[1]=2;v[2]=10;v[3]=8;v[4]=4;v[5]=7; end
        8'd21: begin v[0]=3;v[1]=4;v[2]=7;v[3]=3;v[4]=0;v[5]=4;v[6]=1;v[7]=2;v[8]=10; end
        8'd22: begin v[0]=9;v[1]=2;v[2]=10;v[3]=9;v[4]=0;v[5]=2;v[6]=8;v[7]=4;v[8]=7; end
        8'd23: begin v[0]=2;v[1]=10;v[2]=9;v[3]=2;v[4]=9;v[5]=7;v[6]=2;v[7]=7;v[8]=3;v[9]=7;v[10]=9;v[11]=4; end
        8'd24: begin v[0]=8;v[1]=4;v[2]=7;v[3]=3;v[4]=11;v[5]=2; end
        8'd25: begin v[0]=11;v[1]=4;v[2]=7;v[3]=11;v[4]=2;v[5]=4;v[6]=2;v[7]=0;v[8]=4; end
        8'd26: begin v[0]=9;v[1]=0;v[2]=1;v[3]=8;v[4]=4;v[5]=7;v[6]=2;v[7]=3;v[8]=11; end
        8'd27: begin v[0]=4;v[1]=7;v[2]=11;v[3]=9;v[4]=4;v[5]=11;v[6]=9;v[7]=11;v[8]=2;v[9]=9;v[10]=2;v[11]=1; end
        8'd28: begin v[0]=3;v[1]=10;v[2]=1;v[3]=3;v[4]=11;v[5]=10;v[6]=7;v[7]=8;v[8]=4; end
        8'd29: begin v[0]=1;v[1]=11;v[2]=10;v[3]=1;v[4]=4;v[5]=11;v[6]=1;v[7]=0;v[8]=4;v[9]=7;v[10]=11;v[11]=4; end
        8'd30: begin v[0]=4;v[1]=7;v[2]=8;v[3]=9;v[4]=0;v[5]=11;v[6]=9;v[7]=11;v[8]=10;v[9]=11;v[10]=0;v[11]=3; end
        8'd31: begin v[0]=4;v[1]=7;v[2]=11;v[3]=4;v[4]=11;v[5]=9;v[6]=9;v[7]=11;v[8]=10; end
        8'd32: begin v[0]=9;v[1]=5;v[2]=4; end
        8'd33: begin v[0]=9;v[1]=5;v[2]=4;v[3]=0;v[4]=8;v[5]=3; end
        8'd34: begin v[0]=0;v[1]=5;v[2]=4;v[3]=1;v[4]=5;v[5]=0; end
        8'd35: begin v[0]=8;v[1]=5;v[2]=4;v[3]=8;v[4]=3;v[5]=5;v[6]=3;v[7]=1;v[8]=5; end
        8'd36: begin v[0]=1;v[1]=2;v[2]=10;v[3]=9;v[4]=5;v[5]=4; end
        8'd37: begin v[0]=3;v[1]=0;v[2]=8;v[3]=1;v[4]=2;v[5]=10;v[6]=4;v[7]=9;v[8]=5; end
        8'd38: begin v[0]=5;v[1]=2;v[2]=10;v[3]=5;v[4]=4;v[5]=2;v[6]=4;v[7]=0;v[8]=2; end
        8'd39: begin v[0]=2;v[1]=10;v[2]=5;v[3]=3;v[4]=2;v[5]=5;v[6]=3;v[7]=5;v[8]=4;v[9]=3;v[10]=4;v[11]=8; end
        8'd40: begin v[0]=9;v[1]=5;v[2]=4;v[3]=2;v[4]=3;v[5]=11; end
        8'd41: begin v[0]=0;v[1]=11;v[2]=2;v[3]=0;v[4]=8;v[5]=11;v[6]=4;v[7]=9;v[8]=5; end
        8'd42: begin v[0]=0;v[1]=5;v[2]=4;v[3]=0;v[4]=1;v[5]=5;v[6]=2;v[7]=3;v[8]=11; end
        8'd43: begin v[0]=2;v[1]=1;v[2]=5;v[3]=2;v[4]=5;v[5]=8;v[6]=2;v[7]=8;v[8]=11;v[9]=4;v[10]=8;v[11]=5; end
        8'd44: begin v[0]=10;v[1]=3;v[2]=11;v[3]=10;v[4]=1;v[5]=3;v[6]=9;v[7]=5;v[8]=4; end
        8'd45: begin v[0]=4;v[1]=9;v[2]=5;v[3]=0;v[4]=8;v[5]=1;v[6]=8;v[7]=10;v[8]=1;v[9]=8;v[10]=11;v[11]=10; end
        8'd46: begin v[0]=5;v[1]=4;v[2]=0;v[3]=5;v[4]=0;v[5]=11;v[6]=5;v[7]=11;v[8]=10;v[9]=11;v[10]=0;v[11]=3; end
        8'd47: begin v[0]=5;v[1]=4;v[2]=8;v[3]=5;v[4]=8;v[5]=10;v[6]=10;v[7]=8;v[8]=11; end
        8'd48: begin v[0]=9;v[1]=7;v[2]=8;v[3]=5;v[4]=7;v[5]=9; end
        8'd49: begin v[0]=9;v[1]=3;v[2]=0;v[3]=9;v[4]=5;v[5]=3;v[6]=5;v[7]=7;v[8]=3; end
        8'd50: begin v[0]=0;v[1]=7;v[2]=8;v[3]=0;v[4]=1;v[5]=7;v[6]=1;v[7]=5;v[8]=7; end
        8'd51: begin v[0]=1;v[1]=5;v[2]=3;v[3]=3;v[4]=5;v[5]=7; end
        8'd52: begin v[0]=9;v[1]=7;v[2]=8;v[3]=9;v[4]=5;v[5]=7;v[6]=10;v[7]=1;v[8]=2; end
        8'd53: begin v[0]=10;v[1]=1;v[2]=2;v[3]=9;v[4]=5;v[5]=0;v[6]=5;v[7]=3;v[8]=0;v[9]=5;v[10]=7;v[11]=3; end
        8'd54: begin v[0]=8;v[1]=0;v[2]=2;v[3]=8;v[4]=2;v[5]=5;v[6]=8;v[7]=5;v[8]=7;v[9]=10;v[10]=5;v[11]=2; end
        8'd55: begin v[0]=2;v[1]=10;v[2]=5;v[3]=2;v[4]=5;v[5]=3;v[6]=3;v[7]=5;v[8]=7; end
        8'd56: begin v[0]=7;v[1]=9;v[2]=5;v[3]=7;v[4]=8;v[5]=9;v[6]=3;v[7]=11;v[8]=2; end
        8'd57: begin v[0]=9;v[1]=5;v[2]=7;v[3]=9;v[4]=7;v[5]=2;v[6]=9;v[7]=2;v[8]=0;v[9]=2;v[10]=7;v[11]=11; end
        8'd58: begin v[0]=2;v[1]=3;v[2]=11;v[3]=0;v[4]=1;v[5]=8;v[6]=1;v[7]=7;v[8]=8;v[9]=1;v[10]=5;v[11]=7; end
        8'd59: begin v[0]=11;v[1]=2;v[2]=1;v[3]=11;v[4]=1;v[5]=7;v[6]=7;v[7]=1;v[8]=5; end
        8'd60: begin v[0]=9;v[1]=5;v[2]=8;v[3]=8;v[4]=5;v[5]=7;v[6]=10;v[7]=1;v[8]=3;v[9]=10;v[10]=3;v[11]=11; end
        8'd61: begin v[0]=5;v[1]=7;v[2]=0;v[3]=5;v[4]=0;v[5]=9;v[6]=7;v[7]=11;v[8]=0;v[9]=1;v[10]=0;v[11]=10;v[12]=11;v[13]=10;v[14]=0; end
        8'd62: begin v[0]=11;v[1]=10;v[2]=0;v[3]=11;v[4]=0;v[5]=3;v[6]=10;v[7]=5;v[8]=0;v[9]=8;v[10]=0;v[11]=7;v[12]=5;v[13]=7;v[14]=0; end
        8'd63: begin v[0]=11;v[1]=10;v[2]=5;v[3]=7;v[4]=11;v[5]=5; end
        8'd64: begin v[0]=10;v[1]=6;v[2]=5; end
        8'd65: begin v[0]=0;v[1]=8;v[2]=3;v[3]=5;v[4]=10;v[5]=6; end
        8'd66: begin v[0]=9;v[1]=0;v[2]=1;v[3]=5;v[4]=10;v[5]=6; end
        8'd67: begin v[0]=1;v[1]=8;v[2]=3;v[3]=1;v[4]=9;v[5]=8;v[6]=5;v[7]=10;v[8]=6; end
        8'd68: begin v[0]=1;v[1]=6;v[2]=5;v[3]=2;v[4]=6;v[5]=1; end
        8'd69: begin v[0]=1;v[1]=6;v[2]=5;v[3]=1;v[4]=2;v[5]=6;v[6]=3;v[7]=0;v[8]=8; end
        8'd70: begin v[0]=9;v[1]=6;v[2]=5;v[3]=9;v[4]=0;v[5]=6;v[6]=0;v[7]=2;v[8]=6; end
        8'd71: begin v[0]=5;v[1]=9;v[2]=8;v[3]=5;v[4]=8;v[5]=2;v[6]=5;v[7]=2;v[8]=6;v[9]=3;v[10]=2;v[11]=8; end
        8'd72: begin v[0]=2;v[1]=3;v[2]=11;v[3]=10;v[4]=6;v[5]=5; end
        8'd73: begin v[0]=11;v[1]=0;v[2]=8;v[3]=11;v[4]=2;v[5]=0;v[6]=10;v[7]=6;v[8]=5; end
        8'd74: begin v[0]=0;v[1]=1;v[2]=9;v[3]=2;v[4]=3;v[5]=11;v[6]=5;v[7]=10;v[8]=6; end
        8'd75: begin v[0]=5;v[1]=10;v[2]=6;v[3]=1;v[4]=9;v[5]=2;v[6]=9;v[7]=11;v[8]=2;v[9]=9;v[10]=8;v[11]=11; end
        8'd76: begin v[0]=6;v[1]=3;v[2]=11;v[3]=6;v[4]=5;v[5]=3;v[6]=5;v[7]=1;v[8]=3; end
        8'd77: begin v[0]=0;v[1]=8;v[2]=11;v[3]=0;v[4]=11;v[5]=5;v[6]=0;v[7]=5;v[8]=1;v[9]=5;v[10]=11;v[11]=6; end
        8'd78: begin v[0]=3;v[1]=11;v[2]=6;v[3]=0;v[4]=3;v[5]=6;v[6]=0;v[7]=6;v[8]=5;v[9]=0;v[10]=5;v[11]=9; end
        8'd79: begin v[0]=6;v[1]=5;v[2]=9;v[3]=6;v[4]=9;v[5]=11;v[6]=11;v[7]=9;v[8]=8; end
        8'd80: begin v[0]=5;v[1]=10;v[2]=6;v[3]=4;v[4]=7;v[5]=8; end
        8'd81: begin v[0]=4;v[1]=3;v[2]=0;v[3]=4;v[4]=7;v[5]=3;v[6]=6;v[7]=5;v[8]=10; end
        8'd82: begin v[0]=1;v[1]=9;v[2]=0;v[3]=5;v[4]=10;v[5]=6;v[6]=8;v[7]=4;v[8]=7; end
        8'd83: begin v[0]=10;v[1]=6;v[2]=5;v[3]=1;v[4]=9;v[5]=7;v[6]=1;v[7]=7;v[8]=3;v[9]=7;v[10]=9;v[11]=4; end
        8'd84: begin v[0]=6;v[1]=1;v[2]=2;v[3]=6;v[4]=5;v[5]=1;v[6]=4;v[7]=7;v[8]=8; end
        8'd85: begin v[0]=1;v[1]=2;v[2]=5;v[3]=5;v[4]=2;v[5]=6;v[6]=3;v[7]=0;v[8]=4;v[9]=3;v[10]=4;v[11]=7; end
        8'd86: begin v[0]=8;v[1]=4;v[2]=7;v[3]=9;v[4]=0;v[5]=5;v[6]=0;v[7]=6;v[8]=5;v[9]=0;v[10]=2;v[11]=6; end
        8'd87: begin v[0]=7;v[1]=3;v[2]=9;v[3]=7;v[4]=9;v[5]=4;v[6]=3;v[7]=2;v[8]=9;v[9]=5;v[10]=9;v[11]=6;v[12]=2;v[13]=6;v[14]=9; end
        8'd88: begin v[0]=3;v[1]=11;v[2]=2;v[3]=7;v[4]=8;v[5]=4;v[6]=10;v[7]=6;v[8]=5; end
        8'd89: begin v[0]=5;v[1]=10;v[2]=6;v[3]=4;v[4]=7;v[5]=2;v[6]=4;v[7]=2;v[8]=0;v[9]=2;v[10]=7;v[11]=11; end
        8'd90: begin v[0]=0;v[1]=1;v[2]=9;v[3]=4;v[4]=7;v[5]=8;v[6]=2;v[7]=3;v[8]=11;v[9]=5;v[10]=10;v[11]=6; end
        8'd91: begin v[0]=9;v[1]=2;v[2]=1;v[3]=9;v[4]=11;v[5]=2;v[6]=9;v[7]=4;v[8]=11;v[9]=7;v[10]=11;v[11]=4;v[12]=5;v[13]=10;v[14]=6; end
        8'd92: begin v[0]=8;v[1]=4;v[2]=7;v[3]=3;v[4]=11;v[5]=5;v[6]=3;v[7]=5;v[8]=1;v[9]=5;v[10]=11;v[11]=6; end
        8'd93: begin v[0]=5;v[1]=1;v[2]=11;v[3]=5;v[4]=11;v[5]=6;v[6]=1;v[7]=0;v[8]=11;v[9]=7;v[10]=11;v[11]=4;v[12]=0;v[13]=4;v[14]=11; end
        8'd94: begin v[0]=0;v[1]=5;v[2]=9;v[3]=0;v[4]=6;v[5]=5;v[6]=0;v[7]=3;v[8]=6;v[9]=11;v[10]=6;v[11]=3;v[12]=8;v[13]=4;v[14]=7; end
        8'd95: begin v[0]=6;v[1]=5;v[2]=9;v[3]=6;v[4]=9;v[5]=11;v[6]=4;v[7]=7;v[8]=9;v[9]=7;v[10]=11;v[11]=9; end
        8'd96: begin v[0]=10;v[1]=4;v[2]=9;v[3]=6;v[4]=4;v[5]=10; end
        8'd97: begin v[0]=4;v[1]=10;v[2]=6;v[3]=4;v[4]=9;v[5]=10;v[6]=0;v[7]=8;v[8]=3; end
        8'd98: begin v[0]=10;v[1]=0;v[2]=1;v[3]=10;v[4]=6;v[5]=0;v[6]=6;v[7]=4;v[8]=0; end
        8'd99: begin v[0]=8;v[1]=3;v[2]=1;v[3]=8;v[4]=1;v[5]=6;v[6]=8;v[7]=6;v[8]=4;v[9]=6;v[10]=1;v[11]=10; end
        8'd100: begin v[0]=1;v[1]=4;v[2]=9;v[3]=1;v[4]=2;v[5]=4;v[6]=2;v[7]=6;v[8]=4; end
        8'd101: begin v[0]=3;v[1]=0;v[2]=8;v[3]=1;v[4]=2;v[5]=9;v[6]=2;v[7]=4;v[8]=9;v[9]=2;v[10]=6;v[11]=4; end
        8'd102: begin v[0]=0;v[1]=2;v[2]=4;v[3]=4;v[4]=2;v[5]=6; end
        8'd103: begin v[0]=8;v[1]=3;v[2]=2;v[3]=8;v[4]=2;v[5]=4;v[6]=4;v[7]=2;v[8]=6; end
        8'd104: begin v[0]=10;v[1]=4;v[2]=9;v[3]=10;v[4]=6;v[5]=4;v[6]=11;v[7]=2;v[8]=3; end
        8'd105: begin v[0]=0;v[1]=8;v[2]=2;v[3]=2;v[4]=8;v[5]=11;v[6]=4;v[7]=9;v[8]=10;v[9]=4;v[10]=10;v[11]=6; end
        8'd106: begin v[0]=3;v[1]=11;v[2]=2;v[3]=0;v[4]=1;v[5]=6;v[6]=0;v[7]=6;v[8]=4;v[9]=6;v[10]=1;v[11]=10; end
        8'd107: begin v[0]=6;v[1]=4;v[2]=1;v[3]=6;v[4]=1;v[5]=10;v[6]=4;v[7]=8;v[8]=1;v[9]=2;v[10]=1;v[11]=11;v[12]=8;v[13]=11;v[14]=1; end
        8'd108: begin v[0]=9;v[1]=6;v[2]=4;v[3]=9;v[4]=3;v[5]=6;v[6]=9;v[7]=1;v[8]=3;v[9]=11;v[10]=6;v[11]=3; end
        8'd109: begin v[0]=8;v[1]=11;v[2]=1;v[3]=8;v[4]=1;v[5]=0;v[6]=11;v[7]=6;v[8]=1;v[9]=9;v[10]=1;v[11]=4;v[12]=6;v[13]=4;v[14]=1; end
        8'd110: begin v[0]=3;v[1]=11;v[2]=6;v[3]=3;v[4]=6;v[5]=0;v[6]=0;v[7]=6;v[8]=4; end
        8'd111: begin v[0]=6;v[1]=4;v[2]=8;v[3]=11;v[4]=6;v[5]=8; end
        8'd112: begin v[0]=7;v[1]=10;v[2]=6;v[3]=7;v[4]=8;v[5]=10;v[6]=8;v[7]=9;v[8]=10; end
        8'd113: begin v[0]=0;v[1]=7;v[2]=3;v[3]=0;v[4]=10;v[5]=7;v[6]=0;v[7]=9;v[8]=10;v[9]=6;v[10]=7;v[11]=10; end
        8'd114: begin v[0]=10;v[1]=6;v[2]=7;v[3]=1;v[4]=10;v[5]=7;v[6]=1;v[7]=7;v[8]=8;v[9]=1;v[10]=8;v[11]=0; end
        8'd115: begin v[0]=10;v[1]=6;v[2]=7;v[3]=10;v[4]=7;v[5]=1;v[6]=1;v[7]=7;v[8]=3; end
        8'd116: begin v[0]=1;v[1]=2;v[2]=6;v[3]=1;v[4]=6;v[5]=8;v[6]=1;v[7]=8;v[8]=9;v[9]=8;v[10]=6;v[11]=7; end
        8'd117: begin v[0]=2;v[1]=6;v[2]=9;v[3]=2;v[4]=9;v[5]=1;v[6]=6;v[7]=7;v[8]=9;v[9]=0;v[10]=9;v[11]=3;v[12]=7;v[13]=3;v[14]=9; end
        8'd118: begin v[0]=7;v[1]=8;v[2]=0;v[3]=7;v[4]=0;v[5]=6;v[6]=6;v[7]=0;v[8]=2; end
        8'd119: begin v[0]=7;v[1]=3;v[2]=2;v[3]=6;v[4]=7;v[5]=2; end
        8'd120: begin v[0]=2;v[1]=3;v[2]=11;v[3]=10;v[4]=6;v[5]=8;v[6]=10;v[7]=8;v[8]=9;v[9]=8;v[10]=6;v[11]=7; end
        8'd121: begin v[0]=2;v[1]=0;v[2]=7;v[3]=2;v[4]=7;v[5]=11;v[6]=0;v[7]=9;v[8]=7;v[9]=6;v[10]=7;v[11]=10;v[12]=9;v[13]=10;v[14]=7; end
        8'd122: begin v[0]=1;v[1]=8;v[2]=0;v[3]=1;v[4]=7;v[5]=8;v[6]=1;v[7]=10;v[8]=7;v[9]=6;v[10]=7;v[11]=10;v[12]=2;v[13]=3;v[14]=11; end
        8'd123: begin v[0]=11;v[1]=2;v[2]=1;v[3]=11;v[4]=1;v[5]=7;v[6]=10;v[7]=6;v[8]=1;v[9]=6;v[10]=7;v[11]=1; end
        8'd124: begin v[0]=8;v[1]=9;v[2]=6;v[3]=8;v[4]=6;v[5]=7;v[6]=9;v[7]=1;v[8]=6;v[9]=11;v[10]=6;v[11]=3;v[12]=1;v[13]=3;v[14]=6; end
        8'd125: begin v[0]=0;v[1]=9;v[2]=1;v[3]=11;v[4]=6;v[5]=7; end
        8'd126: begin v[0]=7;v[1]=8;v[2]=0;v[3]=7;v[4]=0;v[5]=6;v[6]=3;v[7]=11;v[8]=0;v[9]=11;v[10]=6;v[11]=0; end
        8'd127: begin v[0]=7;v[1]=11;v[2]=6; end
        8'd128: begin v[0]=7;v[1]=6;v[2]=11; end
        8'd129: begin v[0]=3;v[1]=0;v[2]=8;v[3]=11;v[4]=7;v[5]=6; end
        8'd130: begin v[0]=0;v[1]=1;v[2]=9;v[3]=11;v[4]=7;v[5]=6; end
        8'd131: begin v[0]=8;v[1]=1;v[2]=9;v[3]=8;v[4]=3;v[5]=1;v[6]=11;v[7]=7;v[8]=6; end
        8'd132: begin v[0]=10;v[1]=1;v[2]=2;v[3]=6;v[4]=11;v[5]=7; end
        8'd133: begin v[0]=1;v[1]=2;v[2]=10;v[3]=3;v[4]=0;v[5]=8;v[6]=6;v[7]=11;v[8]=7; end
        8'd134: begin v[0]=2;v[1]=9;v[2]=0;v[3]=2;v[4]=10;v[5]=9;v[6]=6;v[7]=11;v[8]=7; end
        8'd135: begin v[0]=6;v[1]=11;v[2]=7;v[3]=2;v[4]=10;v[5]=3;v[6]=10;v[7]=8;v[8]=3;v[9]=10;v[10]=9;v[11]=8; end
        8'd136: begin v[0]=7;v[1]=2;v[2]=3;v[3]=6;v[4]=2;v[5]=7; end
        8'd137: begin v[0]=7;v[1]=0;v[2]=8;v[3]=7;v[4]=6;v[5]=0;v[6]=6;v[7]=2;v[8]=0; end
        8'd138: begin v[0]=2;v[1]=7;v[2]=6;v[3]=2;v[4]=3;v[5]=7;v[6]=0;v[7]=1;v[8]=9; end
        8'd139: begin v[0]=1;v[1]=6;v[2]=2;v[3]=1;v[4]=8;v[5]=6;v[6]=1;v[7]=9;v[8]=8;v[9]=8;v[10]=7;v[11]=6; end
        8'd140: begin v[0]=10;v[1]=7;v[2]=6;v[3]=10;v[4]=1;v[5]=7;v[6]=1;v[7]=3;v[8]=7; end
        8'd141: begin v[0]=10;v[1]=7;v[2]=6;v[3]=1;v[4]=7;v[5]=10;v[6]=1;v[7]=8;v[8]=7;v[9]=1;v[10]=0;v[11]=8; end
        8'd142: begin v[0]=0;v[1]=3;v[2]=7;v[3]=0;v[4]=7;v[5]=10;v[6]=0;v[7]=10;v[8]=9;v[9]=6;v[10]=10;v[11]=7; end
        8'd143: begin v[0]=7;v[1]=6;v[2]=10;v[3]=7;v[4]=10;v[5]=8;v[6]=8;v[7]=10;v[8]=9; end
        8'd144: begin v[0]=6;v[1]=8;v[2]=4;v[3]=11;v[4]=8;v[5]=6; end
        8'd145: begin v[0]=3;v[1]=6;v[2]=11;v[3]=3;v[4]=0;v[5]=6;v[6]=0;v[7]=4;v[8]=6; end
        8'd146: begin v[0]=8;v[1]=6;v[2]=11;v[3]=8;v[4]=4;v[5]=6;v[6]=9;v[7]=0;v[8]=1; end
        8'd147: begin v[0]=9;v[1]=4;v[2]=6;v[3]=9;v[4]=6;v[5]=3;v[6]=9;v[7]=3;v[8]=1;v[9]=11;v[10]=3;v[11]=6; end
        8'd148: begin v[0]=6;v[1]=8;v[2]=4;v[3]=6;v[4]=11;v[5]=8;v[6]=2;v[7]=10;v[8]=1; end
        8'd149: begin v[0]=1;v[1]=2;v[2]=10;v[3]=3;v[4]=0;v[5]=11;v[6]=0;v[7]=6;v[8]=11;v[9]=0;v[10]=4;v[11]=6; end
        8'd150: begin v[0]=4;v[1]=11;v[2]=8;v[3]=4;v[4]=6;v[5]=11;v[6]=0;v[7]=2;v[8]=9;v[9]=2;v[10]=10;v[11]=9; end
        8'd151: begin v[0]=10;v[1]=9;v[2]=3;v[3]=10;v[4]=3;v[5]=2;v[6]=9;v[7]=4;v[8]=3;v[9]=11;v[10]=3;v[11]=6;v[12]=4;v[13]=6;v[14]=3; end
        8'd152: begin v[0]=8;v[1]=2;v[2]=3;v[3]=8;v[4]=4;v[5]=2;v[6]=4;v[7]=6;v[8]=2; end
        8'd153: begin v[0]=0;v[1]=4;v[2]=2;v[3]=4;v[4]=6;v[5]=2; end
        8'd154: begin v[0]=1;v[1]=9;v[2]=0;v[3]=2;v[4]=3;v[5]=4;v[6]=2;v[7]=4;v[8]=6;v[9]=4;v[10]=3;v[11]=8; end
        8'd155: begin v[0]=1;v[1]=9;v[2]=4;v[3]=1;v[4]=4;v[5]=2;v[6]=2;v[7]=4;v[8]=6; end
        8'd156: begin v[0]=8;v[1]=1;v[2]=3;v[3]=8;v[4]=6;v[5]=1;v[6]=8;v[7]=4;v[8]=6;v[9]=6;v[10]=10;v[11]=1; end
        8'd157: begin v[0]=10;v[1]=1;v[2]=0;v[3]=10;v[4]=0;v[5]=6;v[6]=6;v[7]=0;v[8]=4; end
        8'd158: begin v[0]=4;v[1]=6;v[2]=3;v[3]=4;v[4]=3;v[5]=8;v[6]=6;v[7]=10;v[8]=3;v[9]=0;v[10]=3;v[11]=9;v[12]=10;v[13]=9;v[14]=3; end
        8'd159: begin v[0]=10;v[1]=9;v[2]=4;v[3]=6;v[4]=10;v[5]=4; end
        8'd160: begin v[0]=4;v[1]=9;v[2]=5;v[3]=7;v[4]=6;v[5]=11; end
        8'd161: begin v[0]=0;v[1]=8;v[2]=3;v[3]=4;v[4]=9;v[5]=5;v[6]=11;v[7]=7;v[8]=6; end
        8'd162: begin v[0]=5;v[1]=0;v[2]=1;v[3]=5;v[4]=4;v[5]=0;v[6]=7;v[7]=6;v[8]=11; end
        8'd163: begin v[0]=11;v[1]=7;v[2]=6;v[3]=8;v[4]=3;v[5]=4;v[6]=3;v[7]=5;v[8]=4;v[9]=3;v[10]=1;v[11]=5; end
        8'd164: begin v[0]=9;v[1]=5;v[2]=4;v[3]=10;v[4]=1;v[5]=2;v[6]=7;v[7]=6;v[8]=11; end
        8'd165: begin v[0]=6;v[1]=11;v[2]=7;v[3]=1;v[4]=2;v[5]=10;v[6]=0;v[7]=8;v[8]=3;v[9]=4;v[10]=9;v[11]=5; end
        8'd166: begin v[0]=7;v[1]=6;v[2]=11;v[3]=5;v[4]=4;v[5]=10;v[6]=4;v[7]=2;v[8]=10;v[9]=4;v[10]=0;v[11]=2; end
        8'd167: begin v[0]=3;v[1]=4;v[2]=8;v[3]=3;v[4]=5;v[5]=4;v[6]=3;v[7]=2;v[8]=5;v[9]=10;v[10]=5;v[11]=2;v[12]=11;v[13]=7;v[14]=6; end
        8'd168: begin v[0]=7;v[1]=2;v[2]=3;v[3]=7;v[4]=6;v[5]=2;v[6]=5;v[7]=4;v[8]=9; end
        8'd169: begin v[0]=9;v[1]=5;v[2]=4;v[3]=0;v[4]=8;v[5]=6;v[6]=0;v[7]=6;v[8]=2;v[9]=6;v[10]=8;v[11]=7; end
        8'd170: begin v[0]=3;v[1]=6;v[2]=2;v[3]=3;v[4]=7;v[5]=6;v[6]=1;v[7]=5;v[8]=0;v[9]=5;v[10]=4;v[11]=0; end
        8'd171: begin v[0]=6;v[1]=2;v[2]=8;v[3]=6;v[4]=8;v[5]=7;v[6]=2;v[7]=1;v[8]=8;v[9]=4;v[10]=8;v[11]=5;v[12]=1;v[13]=5;v[14]=8; end
        8'd172: begin v[0]=9;v[1]=5;v[2]=4;v[3]=10;v[4]=1;v[5]=6;v[6]=1;v[7]=7;v[8]=6;v[9]=1;v[10]=3;v[11]=7; end
        8'd173: begin v[0]=1;v[1]=6;v[2]=10;v[3]=1;v[4]=7;v[5]=6;v[6]=1;v[7]=0;v[8]=7;v[9]=8;v[10]=7;v[11]=0;v[12]=9;v[13]=5;v[14]=4; end
        8'd174: begin v[0]=4;v[1]=0;v[2]=10;v[3]=4;v[4]=10;v[5]=5;v[6]=0;v[7]=3;v[8]=10;v[9]=6;v[10]=10;v[11]=7;v[12]=3;v[13]=7;v[14]=10; end
        8'd175: begin v[0]=7;v[1]=6;v[2]=10;v[3]=7;v[4]=10;v[5]=8;v[6]=5;v[7]=4;v[8]=10;v[9]=4;v[10]=8;v[11]=10; end
        8'd176: begin v[0]=6;v[1]=9;v[2]=5;v[3]=6;v[4]=11;v[5]=9;v[6]=11;v[7]=8;v[8]=9; end
        8'd177: begin v[0]=3;v[1]=6;v[2]=11;v[3]=0;v[4]=6;v[5]=3;v[6]=0;v[7]=5;v[8]=6;v[9]=0;v[10]=9;v[11]=5; end
        8'd178: begin v[0]=0;v[1]=11;v[2]=8;v[3]=0;v[4]=5;v[5]=11;v[6]=0;v[7]=1;v[8]=5;v[9]=5;v[10]=6;v[11]=11; end
        8'd179: begin v[0]=6;v[1]=11;v[2]=3;v[3]=6;v[4]=3;v[5]=5;v[6]=5;v[7]=3;v[8]=1; end
        8'd180: begin v[0]=1;v[1]=2;v[2]=10;v[3]=9;v[4]=5;v[5]=11;v[6]=9;v[7]=11;v[8]=8;v[9]=11;v[10]=5;v[11]=6; end
        8'd181: begin v[0]=0;v[1]=11;v[2]=3;v[3]=0;v[4]=6;v[5]=11;v[6]=0;v[7]=9;v[8]=6;v[9]=5;v[10]=6;v[11]=9;v[12]=1;v[13]=2;v[14]=10; end
        8'd182: begin v[0]=11;v[1]=8;v[2]=5;v[3]=11;v[4]=5;v[5]=6;v[6]=8;v[7]=0;v[8]=5;v[9]=10;v[10]=5;v[11]=2;v[12]=0;v[13]=2;v[14]=5; end
        8'd183: begin v[0]=6;v[1]=11;v[2]=3;v[3]=6;v[4]=3;v[5]=5;v[6]=2;v[7]=10;v[8]=3;v[9]=10;v[10]=5;v[11]=3; end
        8'd184: begin v[0]=5;v[1]=8;v[2]=9;v[3]=5;v[4]=2;v[5]=8;v[6]=5;v[7]=6;v[8]=2;v[9]=3;v[10]=8;v[11]=2; end
        8'd185: begin v[0]=9;v[1]=5;v[2]=6;v[3]=9;v[4]=6;v[5]=0;v[6]=0;v[7]=6;v[8]=2; end
        8'd186: begin v[0]=1;v[1]=5;v[2]=8;v[3]=1;v[4]=8;v[5]=0;v[6]=5;v[7]=6;v[8]=8;v[9]=3;v[10]=8;v[11]=2;v[12]=6;v[13]=2;v[14]=8; end
        8'd187: begin v[0]=1;v[1]=5;v[2]=6;v[3]=2;v[4]=1;v[5]=6; end
        8'd188: begin v[0]=1;v[1]=3;v[2]=6;v[3]=1;v[4]=6;v[5]=10;v[6]=3;v[7]=8;v[8]=6;v[9]=5;v[10]=6;v[11]=9;v[12]=8;v[13]=9;v[14]=6; end
        8'd189: begin v[0]=10;v[1]=1;v[2]=0;v[3]=10;v[4]=0;v[5]=6;v[6]=9;v[7]=5;v[8]=0;v[9]=5;v[10]=6;v[11]=0; end
        8'd190: begin v[0]=0;v[1]=3;v[2]=8;v[3]=5;v[4]=6;v[5]=10; end
        8'd191: begin v[0]=10;v[1]=5;v[2]=6; end
        8'd192: begin v[0]=11;v[1]=5;v[2]=10;v[3]=7;v[4]=5;v[5]=11; end
        8'd193: begin v[0]=11;v[1]=5;v[2]=10;v[3]=11;v[4]=7;v[5]=5;v[6]=8;v[7]=3;v[8]=0; end
        8'd194: begin v[0]=5;v[1]=11;v[2]=7;v[3]=5;v[4]=10;v[5]=11;v[6]=1;v[7]=9;v[8]=0; end
        8'd195: begin v[0]=10;v[1]=7;v[2]=5;v[3]=10;v[4]=11;v[5]=7;v[6]=9;v[7]=8;v[8]=1;v[9]=8;v[10]=3;v[11]=1; end
        8'd196: begin v[0]=11;v[1]=1;v[2]=2;v[3]=11;v[4]=7;v[5]=1;v[6]=7;v[7]=5;v[8]=1; end
        8'd197: begin v[0]=0;v[1]=8;v[2]=3;v[3]=1;v[4]=2;v[5]=7;v[6]=1;v[7]=7;v[8]=5;v[9]=7;v[10]=2;v[11]=11; end
        8'd198: begin v[0]=9;v[1]=7;v[2]=5;v[3]=9;v[4]=2;v[5]=7;v[6]=9;v[7]=0;v[8]=2;v[9]=2;v[10]=11;v[11]=7; end
        8'd199: begin v[0]=7;v[1]=5;v[2]=2;v[3]=7;v[4]=2;v[5]=11;v[6]=5;v[7]=9;v[8]=2;v[9]=3;v[10]=2;v[11]=8;v[12]=9;v[13]=8;v[14]=2; end
        8'd200: begin v[0]=2;v[1]=5;v[2]=10;v[3]=2;v[4]=3;v[5]=5;v[6]=3;v[7]=7;v[8]=5; end
        8'd201: begin v[0]=8;v[1]=2;v[2]=0;v[3]=8;v[4]=5;v[5]=2;v[6]=8;v[7]=7;v[8]=5;v[9]=10;v[10]=2;v[11]=5; end
        8'd202: begin v[0]=9;v[1]=0;v[2]=1;v[3]=5;v[4]=10;v[5]=3;v[6]=5;v[7]=3;v[8]=7;v[9]=3;v[10]=10;v[11]=2; end
        8'd203: begin v[0]=9;v[1]=8;v[2]=2;v[3]=9;v[4]=2;v[5]=1;v[6]=8;v[7]=7;v[8]=2;v[9]=10;v[10]=2;v[11]=5;v[12]=7;v[13]=5;v[14]=2; end
        8'd204: begin v[0]=1;v[1]=3;v[2]=5;v[3]=3;v[4]=7;v[5]=5; end
        8'd205: begin v[0]=0;v[1]=8;v[2]=7;v[3]=0;v[4]=7;v[5]=1;v[6]=1;v[7]=7;v[8]=5; end
        8'd206: begin v[0]=9;v[1]=0;v[2]=3;v[3]=9;v[4]=3;v[5]=5;v[6]=5;v[7]=3;v[8]=7; end
        8'd207: begin v[0]=9;v[1]=8;v[2]=7;v[3]=5;v[4]=9;v[5]=7; end
        8'd208: begin v[0]=5;v[1]=8;v[2]=4;v[3]=5;v[4]=10;v[5]=8;v[6]=10;v[7]=11;v[8]=8; end
        8'd209: begin v[0]=5;v[1]=0;v[2]=4;v[3]=5;v[4]=11;v[5]=0;v[6]=5;v[7]=10;v[8]=11;v[9]=11;v[10]=3;v[11]=0; end
        8'd210: begin v[0]=0;v[1]=1;v[2]=9;v[3]=8;v[4]=4;v[5]=10;v[6]=8;v[7]=10;v[8]=11;v[9]=10;v[10]=4;v[11]=5; end
        8'd211: begin v[0]=10;v[1]=11;v[2]=4;v[3]=10;v[4]=4;v[5]=5;v[6]=11;v[7]=3;v[8]=4;v[9]=9;v[10]=4;v[11]=1;v[12]=3;v[13]=1;v[14]=4; end
        8'd212: begin v[0]=2;v[1]=5;v[2]=1;v[3]=2;v[4]=8;v[5]=5;v[6]=2;v[7]=11;v[8]=8;v[9]=4;v[10]=5;v[11]=8; end
        8'd213: begin v[0]=0;v[1]=4;v[2]=11;v[3]=0;v[4]=11;v[5]=3;v[6]=4;v[7]=5;v[8]=11;v[9]=2;v[10]=11;v[11]=1;v[12]=5;v[13]=1;v[14]=11; end
        8'd214: begin v[0]=0;v[1]=2;v[2]=5;v[3]=0;v[4]=5;v[5]=9;v[6]=2;v[7]=11;v[8]=5;v[9]=4;v[10]=5;v[11]=8;v[12]=11;v[13]=8;v[14]=5; end
        8'd215: begin v[0]=9;v[1]=4;v[2]=5;v[3]=2;v[4]=11;v[5]=3; end
        8'd216: begin v[0]=2;v[1]=5;v[2]=10;v[3]=3;v[4]=5;v[5]=2;v[6]=3;v[7]=4;v[8]=5;v[9]=3;v[10]=8;v[11]=4; end
        8'd217: begin v[0]=5;v[1]=10;v[2]=2;v[3]=5;v[4]=2;v[5]=4;v[6]=4;v[7]=2;v[8]=0; end
        8'd218: begin v[0]=3;v[1]=10;v[2]=2;v[3]=3;v[4]=5;v[5]=10;v[6]=3;v[7]=8;v[8]=5;v[9]=4;v[10]=5;v[11]=8;v[12]=0;v[13]=1;v[14]=9; end
        8'd219: begin v[0]=5;v[1]=10;v[2]=2;v[3]=5;v[4]=2;v[5]=4;v[6]=1;v[7]=9;v[8]=2;v[9]=9;v[10]=4;v[11]=2; end
        8'd220: begin v[0]=8;v[1]=4;v[2]=5;v[3]=8;v[4]=5;v[5]=3;v[6]=3;v[7]=5;v[8]=1; end
        8'd221: begin v[0]=0;v[1]=4;v[2]=5;v[3]=1;v[4]=0;v[5]=5; end
        8'd222: begin v[0]=8;v[1]=4;v[2]=5;v[3]=8;v[4]=5;v[5]=3;v[6]=9;v[7]=0;v[8]=5;v[9]=0;v[10]=3;v[11]=5; end
        8'd223: begin v[0]=9;v[1]=4;v[2]=5; end
        8'd224: begin v[0]=4;v[1]=11;v[2]=7;v[3]=4;v[4]=9;v[5]=11;v[6]=9;v[7]=10;v[8]=11; end
        8'd225: begin v[0]=0;v[1]=8;v[2]=3;v[3]=4;v[4]=9;v[5]=7;v[6]=9;v[7]=11;v[8]=7;v[9]=9;v[10]=10;v[11]=11; end
        8'd226: begin v[0]=1;v[1]=10;v[2]=11;v[3]=1;v[4]=11;v[5]=4;v[6]=1;v[7]=4;v[8]=0;v[9]=7;v[10]=4;v[11]=11; end
        8'd227: begin v[0]=3;v[1]=1;v[2]=4;v[3]=3;v[4]=4;v[5]=8;v[6]=1;v[7]=10;v[8]=4;v[9]=7;v[10]=4;v[11]=11;v[12]=10;v[13]=11;v[14]=4; end
        8'd228: begin v[0]=4;v[1]=11;v[2]=7;v[3]=9;v[4]=11;v[5]=4;v[6]=9;v[7]=2;v[8]=11;v[9]=9;v[10]=1;v[11]=2; end
        8'd229: begin v[0]=9;v[1]=7;v[2]=4;v[3]=9;v[4]=11;v[5]=7;v[6]=9;v[7]=1;v[8]=11;v[9]=2;v[10]=11;v[11]=1;v[12]=0;v[13]=8;v[14]=3; end
        8'd230: begin v[0]=11;v[1]=7;v[2]=4;v[3]=11;v[4]=4;v[5]=2;v[6]=2;v[7]=4;v[8]=0; end
        8'd231: begin v[0]=11;v[1]=7;v[2]=4;v[3]=11;v[4]=4;v[5]=2;v[6]=8;v[7]=3;v[8]=4;v[9]=3;v[10]=2;v[11]=4; end
        8'd232: begin v[0]=2;v[1]=9;v[2]=10;v[3]=2;v[4]=7;v[5]=9;v[6]=2;v[7]=3;v[8]=7;v[9]=7;v[10]=4;v[11]=9; end
        8'd233: begin v[0]=9;v[1]=10;v[2]=7;v[3]=9;v[4]=7;v[5]=4;v[6]=10;v[7]=2;v[8]=7;v[9]=8;v[10]=7;v[11]=0;v[12]=2;v[13]=0;v[14]=7; end
        8'd234: begin v[0]=3;v[1]=7;v[2]=10;v[3]=3;v[4]=10;v[5]=2;v[6]=7;v[7]=4;v[8]=10;v[9]=1;v[10]=10;v[11]=0;v[12]=4;v[13]=0;v[14]=10; end
        8'd235: begin v[0]=1;v[1]=10;v[2]=2;v[3]=8;v[4]=7;v[5]=4; end
        8'd236: begin v[0]=4;v[1]=9;v[2]=1;v[3]=4;v[4]=1;v[5]=7;v[6]=7;v[7]=1;v[8]=3; end
        8'd237: begin v[0]=4;v[1]=9;v[2]=1;v[3]=4;v[4]=1;v[5]=7;v[6]=0;v[7]=8;v[8]=1;v[9]=8;v[10]=7;v[11]=1; end
        8'd238: begin v[0]=4;v[1]=0;v[2]=3;v[3]=7;v[4]=4;v[5]=3; end
        8'd239: begin v[0]=4;v[1]=8;v[2]=7; end
        8'd240: begin v[0]=9;v[1]=10;v[2]=8;v[3]=10;v[4]=11;v[5]=8; end
        8'd241: begin v[0]=3;v[1]=0;v[2]=9;v[3]=3;v[4]=9;v[5]=11;v[6]=11;v[7]=9;v[8]=10; end
        8'd242: begin v[0]=0;v[1]=1;v[2]=10;v[3]=0;v[4]=10;v[5]=8;v[6]=8;v[7]=10;v[8]=11; end
        8'd243: begin v[0]=3;v[1]=1;v[2]=10;v[3]=11;v[4]=3;v[5]=10; end
        8'd244: begin v[0]=1;v[1]=2;v[2]=11;v[3]=1;v[4]=11;v[5]=9;v[6]=9;v[7]=11;v[8]=8; end
        8'd245: begin v[0]=3;v[1]=0;v[2]=9;v[3]=3;v[4]=9;v[5]=11;v[6]=1;v[7]=2;v[8]=9;v[9]=2;v[10]=11;v[11]=9; end
        8'd246: begin v[0]=0;v[1]=2;v[2]=11;v[3]=8;v[4]=0;v[5]=11; end
        8'd247: begin v[0]=3;v[1]=2;v[2]=11; end
        8'd248: begin v[0]=2;v[1]=3;v[2]=8;v[3]=2;v[4]=8;v[5]=10;v[6]=10;v[7]=8;v[8]=9; end
        8'd249: begin v[0]=9;v[1]=10;v[2]=2;v[3]=0;v[4]=9;v[5]=2; end
        8'd250: begin v[0]=2;v[1]=3;v[2]=8;v[3]=2;v[4]=8;v[5]=10;v[6]=0;v[7]=1;v[8]=8;v[9]=1;v[10]=10;v[11]=8; end
        8'd251: begin v[0]=1;v[1]=10;v[2]=2; end
        8'd252: begin v[0]=1;v[1]=3;v[2]=8;v[3]=9;v[4]=1;v[5]=8; end
        8'd253: begin v[0]=0;v[1]=9;v[2]=1; end
        8'd254: begin v[0]=0;v[1]=3;v[2]=8; end
        default: ;
      endcase
      for (int k = 0; k < 15; k++) r[k*4 +: 4] = v[k];
      return r;
    end
  endfunction

  // Decoded cube handed from the front end to the back end.
  typedef struct packed {
    logic [7:0]            cs;
    logic [11:0]           crossed;
    logic [7:0][15:0]      mag;
    logic [2:0][CoordW-1:0] base;
  } mcce_job_t;

  typedef struct packed {
    logic            item_kind;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [PosW-1:0] pos_z;
    logic [CntW-1:0] index_a;
    logic [CntW-1:0] index_b;
    logic [CntW-1:0] index_c;
    logic            last_of_cube;
  } mcce_res_t;

endpackage

// ===== hw/rtl/mcce_if.sv =====
// Interfaces: valid/ready channels for cubes and results.
interface mcce_cube_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  corner_0;
  logic signed [15:0]  corner_1;
  logic signed [15:0]  corner_2;
  logic signed [15:0]  corner_3;
  logic signed [15:0]  corner_4;
  logic signed [15:0]  corner_5;
  logic signed [15:0]  corner_6;
  logic signed [15:0]  corner_7;
  logic [7:0]          cube_x;
  logic [7:0]          cube_y;
  logic [7:0]          cube_z;
  modport source (output valid, corner_0, corner_1, corner_2, corner_3, corner_4,
                  corner_5, corner_6, corner_7, cube_x, cube_y, cube_z, input ready);
  modport sink (input valid, corner_0, corner_1, corner_2, corner_3, corner_4,
                corner_5, corner_6, corner_7, cube_x, cube_y, cube_z, output ready);
endinterface

interface mcce_res_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pos_z;
  logic [27:0] index_a;
  logic [27:0] index_b;
  logic [27:0] index_c;
  logic        last_of_cube;
  modport source (output valid, item_kind, pos_x, pos_y, pos_z, index_a, index_b,
                  index_c, last_of_cube, input ready);
  modport sink (input valid, item_kind, pos_x, pos_y, pos_z, index_a, index_b,
                index_c, last_of_cube, output ready);
endinterface

// ===== hw/rtl/mcce_front.sv =====
// Front end: accepts cubes, classifies them and queues in-grid surface cubes.
module mcce_front #(
  parameter int MaxRes = 256
) (
  input  logic                clk,
  input  logic                rst,
  mcce_cube_if.sink           cube,
  output logic                job_valid,
  input  logic                job_ready,
  output mcce_pkg::mcce_job_t job
);

  localparam int Depth = 2;

  mcce_pkg::mcce_job_t q [Depth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  logic signed [15:0] c [8];
  logic [7:0]         cs;
  logic               in_grid;
  logic               keep;
  mcce_pkg::mcce_job_t nj;
  logic               push, pop;

  always_comb begin
    c[0] = cube.corner_0; c[1] = cube.corner_1; c[2] = cube.corner_2;
    c[3] = cube.corner_3; c[4] = cube.corner_4; c[5] = cube.corner_5;
    c[6] = cube.corner_6; c[7] = cube.corner_7;
    for (int i = 0; i < 8; i++) begin
      cs[i] = ~c[i][15] && (c[i] != 16'sd0);
      nj.mag[i] = c[i][15] ? 16'(-c[i]) : 16'(c[i]);
    end
    for (int e = 0; e < mcce_pkg::NumEdges; e++) begin
      logic [5:0] ee;
      ee = mcce_pkg::edge_ends(4'(e));
      nj.crossed[e] = cs[ee[5:3]] ^ cs[ee[2:0]];
    end
    nj.cs = cs;
    nj.base[0] = cube.cube_x;
    nj.base[1] = cube.cube_y;
    nj.base[2] = cube.cube_z;
    in_grid = (32'(cube.cube_x) + 32'd2 <= 32'(MaxRes)) &&
              (32'(cube.cube_y) + 32'd2 <= 32'(MaxRes)) &&
              (32'(cube.cube_z) + 32'd2 <= 32'(MaxRes));
    keep = in_grid && (cs != 8'h00) && (cs != 8'hff);
  end

  assign cube.ready = (count != 2'(Depth));
  assign push = cube.valid && cube.ready && keep;
  assign job_valid = (count != 2'd0);
  assign pop = job_valid && job_ready;
  assign job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= nj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'(Depth) |-> !push) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(Depth)) else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1) else $error("count slip");
`endif

endmodule

// ===== hw/rtl/mcce_div.sv =====
// Restoring divider: 9-bit quotient of a 25-bit dividend, one bit a cycle.
module mcce_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [24:0] num,
  input  logic [16:0] den,
  output logic        done,
  output logic [8:0]  quo
);

  // num < 2*den*256 always (|va|*256 + den/2 with |va| <= den), so 9 bits.
  logic [17:0] rem;
  logic [8:0]  q;
  logic [24:0] nsh;
  logic [3:0]  cnt;
  logic        busy;
  logic [17:0] trial;

  assign trial = {rem[16:0], nsh[24]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= busy && !start && (cnt == 4'd8);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd8) busy <= 1'b0;
      end
    end
  end

  // Top 16 dividend bits are below den, so preload them as the remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {2'b00, num[24:9]};
      nsh <= {num[8:0], 16'd0};
      q   <= 9'd0;
    end else if (busy) begin
      nsh <= {nsh[23:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        q   <= {q[7:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[7:0], 1'b0};
      end
    end
  end

  assign quo = q;

endmodule

// ===== hw/rtl/mcce_back.sv =====
// Back end: walks crossed edges to emit vertices, then emits triangles.
module mcce_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  mcce_pkg::mcce_job_t job,
  mcce_res_if.source          res
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EDGE = 5'b00010,
    S_DIV  = 5'b00100,
    S_VOUT = 5'b01000,
    S_TRI  = 5'b10000
  } state_t;

  state_t state;
  mcce_pkg::mcce_job_t cur;
  mcce_pkg::tri_row_t  row;
  logic [3:0]  eidx;
  logic [3:0]  tidx;
  logic [11:0][27:0] vnum;
  logic [27:0] vertex_count;

  logic        div_start, div_done;
  logic [24:0] div_num;
  logic [16:0] div_den;
  logic [8:0]  div_q;

  logic [5:0]  ee;
  logic [2:0]  ca, cb, oa, ob;
  logic [15:0] ma, mb;
  logic [16:0] den_w;
  logic        crossed_now, any_left, tri_more;
  logic [3:0]  ta, tb, tc;
  logic [8:0]  t8;
  logic [2:0][15:0] pos;
  mcce_pkg::mcce_res_t vout_r, tri_r;
  logic        obuf_free;
  logic        emit;

  mcce_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    ee = mcce_pkg::edge_ends(eidx);
    ca = ee[5:3];
    cb = ee[2:0];
    ma = cur.mag[ca];
    mb = cur.mag[cb];
    den_w = {1'b0, ma} + {1'b0, mb};
    div_num = {1'b0, ma, 8'd0} + 25'(den_w[16:1]);
    div_den = den_w;
    crossed_now = cur.crossed[eidx];
    any_left = (eidx != 4'd11) && ((cur.crossed >> (eidx + 4'd1)) != 12'd0);
    ta = row[tidx*4 +: 4];
    tc = row[(tidx+4'd1)*4 +: 4];
    tb = row[(tidx+4'd2)*4 +: 4];
    tri_more = (tidx < 4'd12) && (row[(tidx+4'd3)*4 +: 4] != 4'hf);
    t8 = (div_q > 9'd256) ? 9'd256 : div_q;
    oa = mcce_pkg::corner_off(ca);
    ob = mcce_pkg::corner_off(cb);
    for (int ax = 0; ax < 3; ax++) begin
      logic [16:0] p;
      p = {1'b0, cur.base[ax], 8'd0};
      if (oa[ax] == ob[ax]) p = p + (oa[ax] ? 17'd256 : 17'd0);
      else if (!oa[ax]) p = p + 17'(t8);
      else p = p + 17'd256 - 17'(t8);
      pos[ax] = p[16] ? 16'hffff : p[15:0];
    end
    vout_r = '0;
    vout_r.pos_x = pos[0];
    vout_r.pos_y = pos[1];
    vout_r.pos_z = pos[2];
    vout_r.index_a = vertex_count;
    tri_r = '0;
    tri_r.item_kind = 1'b1;
    tri_r.index_a = vnum[ta];
    tri_r.index_b = vnum[tb];
    tri_r.index_c = vnum[tc];
    tri_r.last_of_cube = !tri_more;
  end

  assign obuf_free = !res.valid || res.ready;
  assign emit = ((state == S_VOUT) || (state == S_TRI)) && obuf_free;
  assign job_ready = (state == S_IDLE);
  assign div_start = (state == S_EDGE) && crossed_now;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) begin
      cur  <= job;
      row  <= mcce_pkg::tri_row(job.cs);
      eidx <= 4'd0;
      tidx <= 4'd0;
    end
    if (state == S_EDGE && !crossed_now) eidx <= eidx + 4'd1;
    if (state == S_VOUT && obuf_free) begin
      vnum[eidx] <= vertex_count;
      eidx <= eidx + 4'd1;
    end
    if (state == S_TRI && obuf_free) tidx <= tidx + 4'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vertex_count <= '0;
      res.valid <= 1'b0;
    end else begin
      if (emit) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (job_valid) state <= S_EDGE;
        S_EDGE: if (crossed_now) state <= S_DIV;
        S_DIV:  if (div_done) state <= S_VOUT;
        S_VOUT: if (obuf_free) begin
          vertex_count <= vertex_count + 28'd1;
          state <= any_left ? S_EDGE : S_TRI;
        end
        S_TRI: if (obuf_free) begin
          if (!tri_more) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Every surface case has a triangle, so the last vertex is never last_of_cube.
  always_ff @(posedge clk) begin
    if (state == S_VOUT && obuf_free) begin
      res.item_kind <= vout_r.item_kind;
      res.pos_x <= vout_r.pos_x; res.pos_y <= vout_r.pos_y; res.pos_z <= vout_r.pos_z;
      res.index_a <= vout_r.index_a; res.index_b <= vout_r.index_b;
      res.index_c <= vout_r.index_c; res.last_of_cube <= vout_r.last_of_cube;
    end else if (state == S_TRI && obuf_free) begin
      res.item_kind <= tri_r.item_kind;
      res.pos_x <= tri_r.pos_x; res.pos_y <= tri_r.pos_y; res.pos_z <= tri_r.pos_z;
      res.index_a <= tri_r.index_a; res.index_b <= tri_r.index_b;
      res.index_c <= tri_r.index_c; res.last_of_cube <= tri_r.last_of_cube;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> res.valid && $stable(res.index_a))
    else $error("result dropped while stalled");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_VOUT && obuf_free) |=> vertex_count == $past(vertex_count) + 28'd1)
    else $error("vertex counter slip");
  a_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV) else $error("divider done out of place");
`endif

endmodule

// ===== hw/rtl/marching_cubes_cell_extract_core.sv =====
// Top level: marching-cubes cell extractor core.
// One cube enters per item on cube; surface cubes produce vertices on each crossed
// edge (in edge order, numbered by a running 28-bit counter) then the case's
// triangles with reversed winding, on res. Empty, full and out-of-grid cubes
// are dropped in the front end and give no results. A surface cube is loaded,
// then the back end steps past each uncrossed edge before the last crossed one,
// and for each crossed edge takes an edge step, a bit-serial divide for the
// interpolation fraction and an output, then outputs each triangle; a two-entry
// queue lets the front keep taking cubes.
module marching_cubes_cell_extract_core #(
  parameter int MAX_RESOLUTION = 256
) (
  input logic         clk,
  input logic         rst,
  mcce_cube_if.sink   cube,
  mcce_res_if.source  res
);

  logic                job_valid, job_ready;
  mcce_pkg::mcce_job_t job;

  // Classify and queue.
  mcce_front #(.MaxRes(MAX_RESOLUTION)) u_front (
    .clk(clk), .rst(rst), .cube(cube),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  // Interpolate and emit.
  mcce_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_ready(job_ready),
    .job(job), .res(res)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the marching-cubes cell extractor: directed and random cubes, checked per result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID      = 256;
  localparam int MAX_SHOWN = 10;
  localparam int HOLD_LONG = 400;
  localparam int ONE       = 256;   // 1.0 in Q8.8
  localparam int NEG_ONE   = -256;

  // Cube geometry: corner offsets and edge endpoints.
  localparam int OFF_X [8] = '{0, 1, 1, 0, 0, 1, 1, 0};
  localparam int OFF_Y [8] = '{0, 0, 1, 1, 0, 0, 1, 1};
  localparam int OFF_Z [8] = '{0, 0, 0, 0, 1, 1, 1, 1};
  localparam int EDGE_A [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
  localparam int EDGE_B [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

  // Triangle table, one hex digit per edge, three digits per triangle.
  localparam string TRI_TAB [256] = '{
    "", "083", "019", "183981",
    "12a", "08312a", "92a029", "2832a8a98",
    "3b2", "0b28b0", "19023b", "1b219b98b",
    "3a1ba3", "0a108a8ba", "3903b9ba9", "98aa8b",
    "478", "430734", "019847", "419471731",
    "12a847", "34730412a", "92a902847", "2a9297273794",
    "8473b2", "b47b24204", "90184723b", "47b94b9b2921",
    "3a13ba784", "1ba14b1047b4", "47890b9bab03", "47b4b99ba",
    "954", "954083", "054150", "854835315",
    "12a954", "30812a495", "52a542402", "2a5325354348",
    "95423b", "0b208b495", "05401523b", "21525828b485",
    "a3ba13954", "4950818a18ba", "54050b5bab03", "54858aa8b",
    "978579", "930953573", "078017157", "153357",
    "978957a12", "a12950530573", "802825857a52", "2a5253357",
    "7957893b2", "95797292027b", "23b018178157", "b21b17715",
    "958857a13a3b", "5705097b010aba0", "ba0b03a50807570", "ba57b5",
    "a65", "0835a6", "9015a6", "1831985a6",
    "165261", "165126308", "965906026", "598582526328",
    "23ba65", "b08b20a65", "01923b5a6", "5a61929b298b",
    "63b653513", "08b0b50515b6", "3b6036065059", "65969bb98",
    "5a6478", "43047365a", "1905a6847", "a65197173794",
    "612651478", "125526304347", "847905065026", "739794329596269",
    "3b2784a65", "5a647242027b", "01947823b5a6", "9219b294b7b45a6",
    "8473b53515b6", "51b5b610b7b404b", "059065036b63847", "65969b4797b9",
    "a4964a", "4a649a083", "a01a60640", "83181686461a",
    "149124264", "308129249264", "024426", "832824426",
    "a49a64b23", "08228b49a4a6", "3b201606461a", "64161a48121b8b1",
    "964936913b63", "8b1810b61914641", "3b6360064", "648b68",
    "7a678a89a", "0730a709a67a", "a671a7178180", "a67a71173",
    "126168189867", "269291679093739", "780706602", "732672",
    "23ba68a89867", "20727b09767a9a7", "1801781a767a23b", "b21b17a61671",
    "896867916b63136", "091b67", "7807063b0b60", "7b6",
    "76b", "308b76", "019b76", "819831b76",
    "a126b7", "12a3086b7", "2902a96b7", "6b72a3a83a98",
    "723627", "708760620", "276237019", "162186198876",
    "a76a17137", "a7617a187108", "03707a0a96a7", "76a7a88a9",
    "684b86", "36b306046", "86b846901", "946963931b36",
    "6846b82a1", "12a30b06b046", "4b846b0292a9", "a93a32943b36463",
    "823842462", "042462", "190234246438", "194142246",
    "8138618466a1", "a10a06604", "4634386a3039a93", "a946a4",
    "49576b", "083495b76", "50154076b", "b76834354315",
    "954a1276b", "6b712a083495", "76b54a42a402", "348354325a52b76",
    "723762549", "954086062687", "362376150540", "628687218485158",
    "954a16176137", "16a176107870954", "40a4a503a6a737a", "76a7a854a48a",
    "6956b9b89", "36b063056095", "0b805b01556b", "6b3635531",
    "12a95b9b8b56", "0b306b09656912a", "b85b56805a52025", "6b36352a3a53",
    "589528562382", "956960062", "158180568382628", "156216",
    "13616a386569896", "a10a06950560", "03856a", "a56",
    "b5a75b", "b5ab75830", "5b75ab190", "a75ab7981831",
    "b12b71751", "08312717572b", "9759279022b7", "75272b592328982",
    "25a235375", "820852875a25", "9015a35373a2", "982921872a25752",
    "135375", "087071175", "903935537", "987597",
    "5845a8ab8", "5045b05abb30", "01984a8aba45", "ab4a45b34941314",
    "2512852b8458", "04b0b345b2b151b", "0250592b5458b85", "9452b3",
    "25a352345384", "5a2524420", "3a235a385458019", "5a2524192942",
    "845853351", "045105", "845853905035", "945",
    "4b749b9ab", "0834979b79ab", "1ab1b414074b", "3143481a474bab4",
    "4b79b492b912", "9749b791b2b1083", "b74b42240", "b74b42834324",
    "29a279237749", "9a7974a27870207", "37a3a274a1a040a", "1a2874",
    "491417713", "491417081871", "403743", "487",
    "9a8ab8", "30939bb9a", "01a0a88ab", "31ab3a",
    "12b1b99b8", "30939b1292b9", "02b80b", "32b",
    "23828aa89", "9a2092", "23828a0181a8", "1a2",
    "138918", "091", "038", ""
  };

  // One cube item; quiet marks a cube for which send_cube owes no results.
  typedef struct packed {
    logic [7:0][15:0] dens;
    logic [7:0]       x;
    logic [7:0]       y;
    logic [7:0]       z;
    logic             quiet;
  } cube_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mcce_cube_if cube_ch ();
  mcce_res_if  res_ch ();

  marching_cubes_cell_extract_core #(
    .MAX_RESOLUTION(GRID)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .cube(cube_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and the queue of results still owed by the block.
  logic [mcce_pkg::CntW-1:0] next_vertex = '0;
  mcce_pkg::mcce_res_t       owed_res [$];
  cube_item_t                dir_tab [$];

  int  mismatches  = 0;
  int  res_checked = 0;
  int  cubes_sent  = 0;
  int  surf_cubes  = 0;
  bit  hold_req    = 1'b0;   // asks the receiver for one long hold-off
  bit  calm        = 1'b0;   // no idling on either side while set

  function automatic void owe(input mcce_pkg::mcce_res_t r);
    owed_res.insert(owed_res.size(), r);
  endfunction

  function automatic void add_row(input cube_item_t c);
    dir_tab.insert(dir_tab.size(), c);
  endfunction

  function automatic int hex_digit(input byte ch);
    return (ch <= "9") ? int'(ch - "0") : int'(ch - "a") + 10;
  endfunction

  function automatic logic [mcce_pkg::PosW-1:0] axis_pos(input int base, input int oa,
                                                         input int ob, input int t8);
    int p;
    p = base * 256;
    if (oa == ob)
      p += oa * 256;
    else if (oa == 0)
      p += t8;
    else
      p += 256 - t8;
    return (p > 65535) ? 16'hffff : p[mcce_pkg::PosW-1:0];
  endfunction

  // Expected results of one cube, appended to owed_res; advances the vertex counter.
  function automatic void extract_cube(input cube_item_t c);
    int        dv [8];
    logic [mcce_pkg::CntW-1:0] vnum [12];
    int        ca, cb, num, den, t8;
    logic [7:0] cs;
    mcce_pkg::mcce_res_t r;
    mcce_pkg::mcce_res_t burst [$];
    string     row;
    cs = '0;
    if (c.x > GRID - 2 || c.y > GRID - 2 || c.z > GRID - 2) return;
    for (int i = 0; i < 8; i++) begin
      dv[i] = $signed(c.dens[i]);
      cs[i] = dv[i] > 0;
    end
    if (cs == 8'h00 || cs == 8'hff) return;
    surf_cubes++;
    for (int e = 0; e < 12; e++) begin
      ca = EDGE_A[e];
      cb = EDGE_B[e];
      vnum[e] = '0;
      if (cs[ca] == cs[cb]) continue;
      num = (dv[ca] < 0) ? -dv[ca] : dv[ca];
      den = num + ((dv[cb] < 0) ? -dv[cb] : dv[cb]);
      t8  = (num * 256 + den / 2) / den;
      if (t8 > 256) t8 = 256;
      r = '0;
      r.pos_x   = axis_pos(c.x, OFF_X[ca], OFF_X[cb], t8);
      r.pos_y   = axis_pos(c.y, OFF_Y[ca], OFF_Y[cb], t8);
      r.pos_z   = axis_pos(c.z, OFF_Z[ca], OFF_Z[cb], t8);
      r.index_a = next_vertex;
      vnum[e]   = next_vertex;
      burst.insert(burst.size(), r);
      next_vertex++;
    end
    // Triangles go out with reversed winding: a, c, b.
    row = TRI_TAB[cs];
    for (int i = 0; i + 2 < row.len(); i += 3) begin
      r = '0;
      r.item_kind = 1'b1;
      r.index_a   = vnum[hex_digit(row[i])];
      r.index_b   = vnum[hex_digit(row[i + 2])];
      r.index_c   = vnum[hex_digit(row[i + 1])];
      burst.insert(burst.size(), r);
    end
    burst[burst.size() - 1].last_of_cube = 1'b1;
    foreach (burst[k]) owe(burst[k]);
  endfunction

  function automatic cube_item_t mk(input int c0, input int c1, input int c2, input int c3,
                                    input int c4, input int c5, input int c6, input int c7,
                                    input int x, input int y, input int z, input bit quiet);
    cube_item_t c;
    c.dens  = {c7[15:0], c6[15:0], c5[15:0], c4[15:0], c3[15:0], c2[15:0], c1[15:0], c0[15:0]};
    c.x     = x[7:0];
    c.y     = y[7:0];
    c.z     = z[7:0];
    c.quiet = quiet;
    return c;
  endfunction

  // Mostly surface cubes with random content, some noise and off-grid cubes.
  function automatic cube_item_t random_cube();
    cube_item_t c;
    logic [7:0] above;
    int         m;
    above = 8'($urandom_range(1, 254));
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        c.dens[i] = 16'($urandom);
      end else begin
        m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32767) : $urandom_range(0, 600);
        if (above[i])
          c.dens[i] = (m == 0) ? 16'd1 : m[15:0];
        else
          c.dens[i] = 16'(-m);
      end
    end
    if ($urandom_range(0, 9) == 0)
      c.dens = {$urandom, $urandom, $urandom, $urandom};
    c.x = 8'($urandom_range(0, 254));
    c.y = 8'($urandom_range(0, 254));
    c.z = 8'($urandom_range(0, 254));
    case ($urandom_range(0, 19))
      0: c.x = 8'hff;
      1: c.y = 8'hff;
      2: c.z = 8'hff;
      default: ;
    endcase
    c.quiet = 1'b0;
    return c;
  endfunction

  // Offer one cube; valid stays high across back-to-back items.
  task automatic send_cube(input cube_item_t c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      cube_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cube_ch.valid    <= 1'b1;
    cube_ch.corner_0 <= c.dens[0];
    cube_ch.corner_1 <= c.dens[1];
    cube_ch.corner_2 <= c.dens[2];
    cube_ch.corner_3 <= c.dens[3];
    cube_ch.corner_4 <= c.dens[4];
    cube_ch.corner_5 <= c.dens[5];
    cube_ch.corner_6 <= c.dens[6];
    cube_ch.corner_7 <= c.dens[7];
    cube_ch.cube_x   <= c.x;
    cube_ch.cube_y   <= c.y;
    cube_ch.cube_z   <= c.z;
    do @(posedge clk); while (!cube_ch.ready);
    cubes_sent++;
    if (!c.quiet) extract_cube(c);
  endtask

  function automatic string show(input mcce_pkg::mcce_res_t r);
    return $sformatf("kind=%0d pos=%04h/%04h/%04h idx=%0d/%0d/%0d last=%0d", r.item_kind,
                     r.pos_x, r.pos_y, r.pos_z, r.index_a, r.index_b, r.index_c,
                     r.last_of_cube);
  endfunction

  // Result side: random stalls, one long hold-off on request, checks every item.
  initial begin : result_side
    int        stall;
    mcce_pkg::mcce_res_t got;
    mcce_pkg::mcce_res_t want;
    res_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        stall    = HOLD_LONG;
        hold_req = 1'b0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      got.item_kind    = res_ch.item_kind;
      got.pos_x        = res_ch.pos_x;
      got.pos_y        = res_ch.pos_y;
      got.pos_z        = res_ch.pos_z;
      got.index_a      = res_ch.index_a;
      got.index_b      = res_ch.index_b;
      got.index_c      = res_ch.index_c;
      got.last_of_cube = res_ch.last_of_cube;
      res_checked++;
      if (owed_res.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected result: %s", show(got));
      end else begin
        want = owed_res.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d mismatch\n  exp %s\n  got %s", res_checked, show(want),
                     show(got));
        end
      end
    end
  end

  initial begin : watchdog
    #3ms;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    mcce_pkg::mcce_res_t r;
    int         hold_left;
    cube_ch.valid    = 1'b0;
    cube_ch.corner_0 = '0;
    cube_ch.corner_1 = '0;
    cube_ch.corner_2 = '0;
    cube_ch.corner_3 = '0;
    cube_ch.corner_4 = '0;
    cube_ch.corner_5 = '0;
    cube_ch.corner_6 = '0;
    cube_ch.corner_7 = '0;
    cube_ch.cube_x   = '0;
    cube_ch.cube_y   = '0;
    cube_ch.cube_z   = '0;

    // Directed rows. The first one is checked against hand-typed results.
    add_row(mk(ONE, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE,
               0, 0, 0, 0));
    // empty (all zero is not above), full, and all most-negative
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 5, 6, 7, 1));
    add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
               254, 254, 254, 1));
    add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
               0, 0, 0, 1));
    // out of grid on each axis, with a surface inside
    add_row(mk(ONE, NEG_ONE, ONE, NEG_ONE, ONE, NEG_ONE, ONE, NEG_ONE, 255, 0, 0, 1));
    add_row(mk(ONE, NEG_ONE, ONE, NEG_ONE, ONE, NEG_ONE, ONE, NEG_ONE, 0, 255, 0, 1));
    add_row(mk(ONE, NEG_ONE, ONE, NEG_ONE, ONE, NEG_ONE, ONE, NEG_ONE, 0, 0, 255, 1));
    // last in-grid corner of the lattice, single corners
    add_row(mk(NEG_ONE, ONE, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE,
               254, 254, 254, 0));
    add_row(mk(-1, -1, -1, -1, -1, -1, -1, 32767, 254, 0, 1, 0));
    add_row(mk(-1, -1, -1, -1, -1, -1, 32767, -1, 0, 254, 2, 0));
    // checkerboards: every edge crossed, extremes of the density range
    add_row(mk(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767,
               1, 2, 3, 0));
    add_row(mk(-1, 1, -1, 1, 1, -1, 1, -1, 254, 254, 0, 0));
    // five-triangle case, rounding and zero-versus-one boundaries
    add_row(mk(300, -20, 7, 900, 40, 1, -300, -5, 100, 50, 25, 0));
    add_row(mk(1, -2, -2, -2, -2, -2, -2, -2, 10, 10, 10, 0));
    add_row(mk(0, -5, -5, -5, -5, -5, 1, -5, 11, 12, 13, 0));
    add_row(mk(-32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
               128, 64, 32, 0));
    add_row(mk(32767, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
               127, 63, 31, 0));
    add_row(mk(2, 0, -3, 0, 5, -7, 0, 1, 200, 100, 50, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First cube after reset: case with corner 0 alone, all fractions one half.
    r = '0;
    r.pos_x = 16'd128;
    owe(r);
    r = '0;
    r.pos_y = 16'd128;
    r.index_a = 28'd1;
    owe(r);
    r = '0;
    r.pos_z = 16'd128;
    r.index_a = 28'd2;
    owe(r);
    r = '0;
    r.item_kind = 1'b1;
    r.index_b = 28'd1;
    r.index_c = 28'd2;
    r.last_of_cube = 1'b1;
    owe(r);
    next_vertex = 28'd3;
    surf_cubes  = 1;
    dir_tab[0].quiet = 1'b1;   // already accounted for above

    foreach (dir_tab[i]) send_cube(dir_tab[i]);

    // Long receiver hold-off while cubes keep coming, so the block backs up.
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_cube(random_cube());

    // Random part, with a stretch of no idling in the middle.
    for (int i = 0; i < 112; i++) begin
      calm = (i >= 50 && i < 80);
      send_cube(random_cube());
    end
    calm = 1'b0;
    cube_ch.valid <= 1'b0;

    while (owed_res.size() != 0) @(posedge clk);
    hold_left = 300;
    repeat (hold_left) @(posedge clk);

    $display("covered %0d cubes (%0d on the surface), %0d results compared, %0d vertices",
             cubes_sent, surf_cubes, res_checked, next_vertex);
    if (mismatches == 0 && owed_res.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, owed_res.size());
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mcce_pkg.sv
hw/rtl/mcce_if.sv
hw/rtl/mcce_front.sv
hw/rtl/mcce_div.sv
hw/rtl/mcce_back.sv
hw/rtl/marching_cubes_cell_extract_core.sv
tb/sv/testbench.sv
